// File: rtl/core/lfr_pkg.sv
// lfr_pkg: shared sizes, payload structs and controller/datapath command types
// for the LRU frame replacement block. No dependencies.
`timescale 1ns / 1ps

package lfr_pkg;

    // table geometry
    localparam int MAX_FRAMES = 32;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = 6;
    localparam int PAGE_BITS  = 20;
    localparam int STAMP_BITS = 32;

    localparam logic [COUNT_W-1:0] CFG_RESET = COUNT_W'(MAX_FRAMES);

    // input transaction
    typedef struct packed {
        logic [COUNT_W-1:0]   frame_index;
        logic [PAGE_BITS-1:0] new_page;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [FRAME_W-1:0]   chosen_frame;
        logic                 was_miss;
        logic                 evicted;
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 stamp_wrapped;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // capture input transaction
        logic decide;   // hit / empty-frame decision, start scan on a full miss
        logic scan;     // one stamp compare per cycle
        logic page_rd;  // read the victim's page
        logic commit;   // update table, load result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic empty_found;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

    // frames_in_use clamped to 1..MAX_FRAMES
    function automatic logic [COUNT_W-1:0] managed_count(input logic [COUNT_W-1:0] cfg);
        logic [COUNT_W-1:0] n;
        n = cfg;
        if (cfg == '0) begin
            n = COUNT_W'(1);
        end else if (cfg > COUNT_W'(MAX_FRAMES)) begin
            n = COUNT_W'(MAX_FRAMES);
        end
        return n;
    endfunction

endpackage

// File: rtl/core/lru_frame_replacement.sv
// lru_frame_replacement: top level of the LRU page frame replacement block.
// Depends on lfr_pkg, lfr_ctrl, lfr_dp, lfr_ram.
//
//  Channel   Signals                            Moves
//  -------   --------------------------------   ---------------------------------
//  in        i_in_valid / o_in_ready            t_in_item: frame_index, new_page
//  out       o_out_valid / i_out_ready          t_out_item: chosen frame, flags
//  cfg       i_cfg_we / i_cfg_data              frames_in_use, no handshake wait
//
// A hit or a miss that finds an empty frame goes from the decision straight to
// the commit. A miss on a full table scans the stamp RAM one frame a cycle over
// the n managed frames, then reads the victim's page ahead of the commit.
// One transaction is in work at a time; a result waiting in the output
// register stalls only the final commit. Synchronous active-low reset clears
// the valid bits, stamp counter and frames_in_use (to 32); no clearing pass.
`timescale 1ns / 1ps

module lru_frame_replacement (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfr_pkg::COUNT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lfr_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lfr_pkg::t_out_item          o_out_data
);

    lfr_pkg::t_dp_cmd cmd;
    lfr_pkg::t_dp_sts sts;

    lfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// File: rtl/core/lfr_ram.sv
// lfr_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lfr_ctrl.sv
// lfr_ctrl: sequencing FSM for the LRU frame replacement block.
// Depends on lfr_pkg.
`timescale 1ns / 1ps

module lfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lfr_pkg::t_dp_sts i_sts,
    output lfr_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_PAGE_RD,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // commands from current state
    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = r_in_ready && i_in_valid;
        o_cmd.decide  = (r_state == ST_DECIDE);
        o_cmd.scan    = (r_state == ST_SCAN);
        o_cmd.page_rd = (r_state == ST_PAGE_RD);
        o_cmd.commit  = (r_state == ST_FINISH) && i_sts.out_free;
    end

    assign o_in_ready = r_in_ready;

    // state and ready register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (o_cmd.accept) begin
                        r_state    <= ST_DECIDE;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_DECIDE: begin
                    if (i_sts.hit || i_sts.empty_found) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (i_sts.scan_last) begin
                        r_state <= ST_PAGE_RD;
                    end
                end
                ST_PAGE_RD: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/lfr_dp.sv
// lfr_dp: frame table, stamp counter, LRU scan and result register.
// Depends on lfr_pkg and lfr_ram.
`timescale 1ns / 1ps

module lfr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfr_pkg::COUNT_W-1:0]     i_cfg_data,
    input  lfr_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lfr_pkg::t_out_item              o_out_data,
    input  lfr_pkg::t_dp_cmd                i_cmd,
    output lfr_pkg::t_dp_sts                o_sts
);

    logic [lfr_pkg::COUNT_W-1:0]    r_frames_in_use;
    logic [lfr_pkg::COUNT_W-1:0]    n_count;
    logic [lfr_pkg::MAX_FRAMES-1:0] r_valid;
    logic [lfr_pkg::STAMP_BITS-1:0] r_stamp_cnt;

    logic [lfr_pkg::COUNT_W-1:0]    r_idx;
    logic [lfr_pkg::PAGE_BITS-1:0]  r_page;
    logic [lfr_pkg::FRAME_W-1:0]    r_chosen;
    logic                           r_miss;
    logic                           r_evict;

    logic [lfr_pkg::COUNT_W-1:0]    r_scan_addr;
    logic [lfr_pkg::FRAME_W-1:0]    r_cmp_idx;
    logic                           r_first;
    logic [lfr_pkg::STAMP_BITS-1:0] r_best;

    logic                           r_out_valid;
    lfr_pkg::t_out_item             r_out;

    logic                           hit;
    logic                           empty_found;
    logic [lfr_pkg::FRAME_W-1:0]    empty_idx;
    logic                           full_miss;
    logic                           scan_last;
    logic                           out_free;

    logic                           stamp_re;
    logic [lfr_pkg::FRAME_W-1:0]    stamp_raddr;
    logic [lfr_pkg::STAMP_BITS-1:0] stamp_rdata;
    logic [lfr_pkg::PAGE_BITS-1:0]  page_rdata;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= lfr_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    assign n_count = lfr_pkg::managed_count(r_frames_in_use);

    // lowest invalid frame within the managed count
    always_comb begin
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int k = 0; k < lfr_pkg::MAX_FRAMES; k++) begin
            if (!empty_found && !r_valid[k]
                && (lfr_pkg::COUNT_W'(k) < n_count)) begin
                empty_found = 1'b1;
                empty_idx   = lfr_pkg::FRAME_W'(k);
            end
        end
    end

    assign hit       = (r_idx < n_count);
    assign full_miss = !hit && !empty_found;
    assign scan_last = ({1'b0, r_cmp_idx} == (n_count - lfr_pkg::COUNT_W'(1)));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts             = '0;
        o_sts.hit         = hit;
        o_sts.empty_found = empty_found;
        o_sts.scan_last   = scan_last;
        o_sts.out_free    = out_free;
    end

    // stamp read address: frame 0 at decide, then one per scan cycle
    assign stamp_re    = (i_cmd.decide && full_miss)
                       || (i_cmd.scan && (r_scan_addr < n_count));
    assign stamp_raddr = i_cmd.decide ? '0 : r_scan_addr[lfr_pkg::FRAME_W-1:0];

    lfr_ram #(
        .WIDTH (lfr_pkg::STAMP_BITS),
        .DEPTH (lfr_pkg::MAX_FRAMES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_chosen),
        .i_wdata (r_stamp_cnt),
        .i_re    (stamp_re),
        .i_raddr (stamp_raddr),
        .o_rdata (stamp_rdata)
    );

    lfr_ram #(
        .WIDTH (lfr_pkg::PAGE_BITS),
        .DEPTH (lfr_pkg::MAX_FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && r_miss),
        .i_waddr (r_chosen),
        .i_wdata (r_page),
        .i_re    (i_cmd.page_rd),
        .i_raddr (r_chosen),
        .o_rdata (page_rdata)
    );

    // transaction capture, decision and LRU scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= i_in_data.frame_index;
            r_page <= i_in_data.new_page;
        end
        if (i_cmd.decide) begin
            r_scan_addr <= lfr_pkg::COUNT_W'(1);
            r_cmp_idx   <= '0;
            r_first     <= 1'b1;
            if (hit) begin
                r_chosen <= r_idx[lfr_pkg::FRAME_W-1:0];
                r_miss   <= 1'b0;
                r_evict  <= 1'b0;
            end else if (empty_found) begin
                r_chosen <= empty_idx;
                r_miss   <= 1'b1;
                r_evict  <= 1'b0;
            end else begin
                r_chosen <= '0;
                r_miss   <= 1'b1;
                r_evict  <= 1'b1;
            end
        end
        if (i_cmd.scan) begin
            // strict less-than keeps the lower index on ties
            if (r_first || (stamp_rdata < r_best)) begin
                r_best   <= stamp_rdata;
                r_chosen <= r_cmp_idx;
            end
            r_first   <= 1'b0;
            r_cmp_idx <= r_cmp_idx + lfr_pkg::FRAME_W'(1);
            if (r_scan_addr < n_count) begin
                r_scan_addr <= r_scan_addr + lfr_pkg::COUNT_W'(1);
            end
        end
    end

    // table state and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_stamp_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_stamp_cnt <= r_stamp_cnt + lfr_pkg::STAMP_BITS'(1);
            if (r_miss) begin
                r_valid[r_chosen] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.chosen_frame  <= r_chosen;
            r_out.was_miss      <= r_miss;
            r_out.evicted       <= r_evict;
            r_out.evicted_page  <= r_evict ? page_rdata : '0;
            r_out.stamp_wrapped <= &r_stamp_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/lfr_checker.sv
// lfr_checker: port-level assertions for lru_frame_replacement, bound to the top.
// Depends on lfr_pkg and lru_frame_replacement.
`timescale 1ns / 1ps

module lfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lfr_pkg::t_out_item o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // eviction only happens on a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.evicted |-> o_out_data.was_miss)
        else $error("eviction reported on a hit");

    // no evicted page without an eviction
    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.evicted |-> o_out_data.evicted_page == '0)
        else $error("evicted page nonzero without eviction");

endmodule

bind lru_frame_replacement lfr_checker u_lfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: dv/tb_lru_frame_replacement.sv
`timescale 1ns / 1ps
// tb_lru_frame_replacement: self-checking bench for the LRU frame replacement block.
// A scoreboard class tracks frame state and use stamps and checks each result.
// Depends on lfr_pkg and lru_frame_replacement.

module tb_lru_frame_replacement;
    import lfr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 43;

    // Frame table tracker: predicts each access and holds the results still due
    class lru_frame_tracker;
        bit                  valid_bits [MAX_FRAMES];
        bit [PAGE_BITS-1:0]  pages      [MAX_FRAMES];
        bit [STAMP_BITS-1:0] stamps     [MAX_FRAMES];
        bit [STAMP_BITS-1:0] stamp_ctr;
        bit [COUNT_W-1:0]    frame_count = CFG_RESET;
        t_out_item           due_results [$];
        int                  access_count;
        int                  miss_count;
        int                  evict_count;
        int                  result_count;
        int                  mismatch_count;

        // count register clamped to 1..MAX_FRAMES
        function int managed_frames();
            if (frame_count == '0) return 1;
            if (frame_count > MAX_FRAMES) return MAX_FRAMES;
            return int'(frame_count);
        endfunction

        function void set_frame_count(bit [COUNT_W-1:0] value);
            frame_count = value;
        endfunction

        // accepted access: update the table and queue the expected result
        function void note_access(t_in_item acc);
            int                  n;
            int                  sel;
            bit                  found;
            bit [STAMP_BITS-1:0] best;
            t_out_item           res;
            n   = managed_frames();
            res = '0;
            sel = int'(acc.frame_index);
            if (acc.frame_index >= n) begin
                // miss: lowest empty frame first, else oldest stamp
                found = 1'b0;
                sel   = 0;
                for (int k = 0; k < n; k++) begin
                    if (!valid_bits[k] && !found) begin
                        sel   = k;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    best = stamps[0];
                    for (int k = 1; k < n; k++) begin
                        if (stamps[k] < best) begin
                            best = stamps[k];
                            sel  = k;
                        end
                    end
                    res.evicted      = 1'b1;
                    res.evicted_page = pages[sel];
                    evict_count++;
                end
                valid_bits[sel] = 1'b1;
                pages[sel]      = acc.new_page;
                res.was_miss    = 1'b1;
                miss_count++;
            end
            // hit or miss, the chosen frame takes the current stamp
            stamps[sel]       = stamp_ctr;
            stamp_ctr         = stamp_ctr + 1'b1;
            res.stamp_wrapped = (stamp_ctr == '0);
            res.chosen_frame  = sel[FRAME_W-1:0];
            due_results.push_back(res);
            access_count++;
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            result_count++;
            if (due_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: frame=%0d miss=%0b evict=%0b page=%h wrap=%0b",
                             got.chosen_frame, got.was_miss, got.evicted, got.evicted_page,
                             got.stamp_wrapped);
                return;
            end
            want = due_results.pop_front();
            if (got.chosen_frame !== want.chosen_frame || got.was_miss !== want.was_miss ||
                got.evicted !== want.evicted || got.evicted_page !== want.evicted_page ||
                got.stamp_wrapped !== want.stamp_wrapped) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result %0d wrong: exp frame=%0d miss=%0b evict=%0b page=%h wrap=%0b",
                             result_count, want.chosen_frame, want.was_miss, want.evicted,
                             want.evicted_page, want.stamp_wrapped);
                    $display("                  got frame=%0d miss=%0b evict=%0b page=%h wrap=%0b",
                             got.chosen_frame, got.was_miss, got.evicted, got.evicted_page,
                             got.stamp_wrapped);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    t_in_item           in_data;
    logic               out_valid;
    logic               out_ready;
    t_out_item          out_data;

    lru_frame_tracker sb = new();
    bit               steady = 1'b0;
    int               cycle_count = 0;
    int               phase_count = 1;

    lru_frame_replacement dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit, %0d results still due",
                     sb.due_results.size());
            $display("lru_frame_replacement: mismatch");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // result side: random stall bursts, none once steady
    initial begin
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (!steady && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    // one access transaction, with an optional idle burst ahead of it
    task automatic send_access(bit [COUNT_W-1:0] idx, bit [PAGE_BITS-1:0] page);
        t_in_item acc;
        acc.frame_index = idx;
        acc.new_page    = page;
        if (!steady && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= acc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_access(acc);
    endtask

    // hold off the sender until every due result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge clk);
    endtask

    // count register write, only with the block idle
    task automatic write_frame_count(bit [COUNT_W-1:0] value);
        drain_results();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        sb.set_frame_count(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    function automatic bit [PAGE_BITS-1:0] random_page();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PAGE_BITS'($urandom);
        endcase
    endfunction

    // mostly hits on managed frames and plain misses, some arbitrary indexes
    function automatic bit [COUNT_W-1:0] random_index(int n);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return COUNT_W'($urandom_range(0, n - 1));
        if (roll < 88) return COUNT_W'(n);
        return COUNT_W'($urandom_range(0, 63));
    endfunction

    task automatic run_random_accesses(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 79) == 0)
                drain_results();
            send_access(random_index(sb.managed_frames()), random_page());
        end
    endtask

    initial begin
        bit [COUNT_W-1:0] settings [10];
        settings    = '{6'd4, 6'd32, 6'd1, 6'd63, 6'd8, 6'd0, 6'd33, 6'd3, 6'd0, 6'd16};
        settings[8] = COUNT_W'($urandom_range(2, 31));
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset count of 32: hits on empty frames, misses filling from the bottom
        send_access(6'd0, '1);
        send_access(6'd31, 20'h12345);
        send_access(6'd32, '1);
        send_access(6'd63, '0);
        send_access(6'd40, 20'hAAAAA);
        send_access(6'd1, '0);
        // two frames, both full: evictions by oldest stamp
        write_frame_count(6'd2);
        send_access(6'd2, 20'h55555);
        send_access(6'd0, 20'hFFFF0);
        send_access(6'd5, 20'h0F0F0);
        send_access(6'd62, 20'h00001);
        // raised to three: frame 2 kept its page from before
        write_frame_count(6'd3);
        send_access(6'd3, 20'h33333);
        send_access(6'd2, '0);
        // zero count acts as one frame
        write_frame_count(6'd0);
        send_access(6'd1, 20'h80000);
        send_access(6'd0, 20'h7FFFF);
        send_access(6'd31, 20'hCAFE0);
        // counts above the table size saturate
        write_frame_count(6'd63);
        send_access(6'd32, 20'h0000F);
        send_access(6'd33, 20'hF0000);
        send_access(6'd31, 20'h11111);
        write_frame_count(6'd33);
        send_access(6'd33, 20'h22222);
        send_access(6'd16, 20'h44444);

        // random phases over several counts, the last one without idling
        for (int p = 0; p < 10; p++) begin
            if (p == 9) steady = 1'b1;
            write_frame_count(settings[p]);
            run_random_accesses(PHASE_ITEMS);
        end

        drain_results();
        repeat (50) @(posedge clk);
        $display("covered %0d accesses, %0d misses, %0d evictions over %0d count settings",
                 sb.access_count, sb.miss_count, sb.evict_count, phase_count);
        $display("checked %0d results, %0d mismatches", sb.result_count, sb.mismatch_count);
        if (sb.mismatch_count == 0 && sb.due_results.size() == 0)
            $display("lru_frame_replacement: match");
        else
            $display("lru_frame_replacement: mismatch");
        $finish;
    end

endmodule
